>>> rtl/smxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smxc_pkg
// Shared types and constants for the SplitMix32 keystream XOR byte cipher.
// ----------------------------------------------------------------------------
package smxc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STR_IDX_W = 16;
    localparam int unsigned LANE_W    = 2;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 32'h85EB_CA6B;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 32'hC2B2_AE35;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic mul_a;    // first mixing multiply
        logic mul_b;    // second mixing multiply
        logic finish;   // final xorshift, load key word and output
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_mix; // offered byte starts a new key word
        logic out_free; // output register can take a result this cycle
    } t_dp_sts;

endpackage

>>> rtl/smxc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smxc_ctrl
// Sequencer: accepts bytes and steps the key word mix through two multiplies.
// ----------------------------------------------------------------------------
module smxc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  smxc_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output smxc_pkg::t_dp_cmd o_cmd
);

    smxc_pkg::t_state r_state;
    smxc_pkg::t_state n_state;
    logic             w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smxc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a byte on an existing key word goes straight to the output register
    assign w_ready = (r_state == smxc_pkg::ST_IDLE) && (i_sts.need_mix || i_sts.out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            smxc_pkg::ST_IDLE: begin
                if (i_in_valid && w_ready && i_sts.need_mix) begin
                    n_state = smxc_pkg::ST_MUL_A;
                end
            end
            smxc_pkg::ST_MUL_A: begin
                n_state = smxc_pkg::ST_MUL_B;
            end
            smxc_pkg::ST_MUL_B: begin
                n_state = smxc_pkg::ST_FINISH;
            end
            smxc_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = smxc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smxc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            smxc_pkg::ST_IDLE: begin
                o_in_stall   = !w_ready;
                o_cmd.accept = i_in_valid && w_ready;
            end
            smxc_pkg::ST_MUL_A: begin
                o_cmd.mul_a = 1'b1;
            end
            smxc_pkg::ST_MUL_B: begin
                o_cmd.mul_b = 1'b1;
            end
            smxc_pkg::ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/smxc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smxc_dp
// Generator state, key word mixer, lane select and output register.
// ----------------------------------------------------------------------------
module smxc_dp #(
    parameter int INDEX_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smxc_pkg::WORD_W-1:0]      i_cfg_wdata,
    input  logic [smxc_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_first_byte,
    input  logic [smxc_pkg::STR_IDX_W-1:0]   i_string_index,
    input  logic                             i_out_stall,
    input  smxc_pkg::t_dp_cmd                i_cmd,
    output smxc_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    output logic [smxc_pkg::BYTE_W-1:0]      o_result_byte
);

    localparam int KEEP_BITS = (INDEX_BITS < smxc_pkg::STR_IDX_W) ?
                               INDEX_BITS : smxc_pkg::STR_IDX_W;

    logic [smxc_pkg::WORD_W-1:0] r_seed;
    logic [smxc_pkg::WORD_W-1:0] r_gen;
    logic [smxc_pkg::WORD_W-1:0] r_key;
    logic [smxc_pkg::LANE_W-1:0] r_lane;
    logic [smxc_pkg::WORD_W-1:0] r_z;
    logic [smxc_pkg::BYTE_W-1:0] r_data;
    logic [smxc_pkg::BYTE_W-1:0] r_out;
    logic                        r_out_valid;

    logic [smxc_pkg::WORD_W-1:0] w_idx;
    logic [smxc_pkg::WORD_W-1:0] w_base;
    logic [smxc_pkg::WORD_W-1:0] n_gen;
    logic [smxc_pkg::WORD_W-1:0] w_z_b;
    logic [smxc_pkg::WORD_W-1:0] w_key;
    logic                        w_load_out;

    assign w_idx  = smxc_pkg::WORD_W'(i_string_index[KEEP_BITS-1:0]);
    assign w_base = i_first_byte ? (r_seed ^ w_idx) : r_gen;
    assign n_gen  = w_base + smxc_pkg::GOLDEN_STEP;
    assign w_z_b  = r_z ^ (r_z >> 13);
    assign w_key  = r_z ^ (r_z >> 16);

    assign o_sts.need_mix = i_first_byte || (r_lane == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign w_load_out = (i_cmd.accept && !o_sts.need_mix) || i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_gen       <= '0;
            r_key       <= '0;
            r_lane      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (o_sts.need_mix) begin
                    r_gen  <= n_gen;
                    r_lane <= '0;
                end else begin
                    r_lane <= r_lane + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_key  <= w_key;
                r_lane <= smxc_pkg::LANE_W'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // mixer pipeline, one multiply per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data <= i_data_byte;
            r_z    <= n_gen ^ (n_gen >> 16);
        end else if (i_cmd.mul_a) begin
            r_z <= r_z * smxc_pkg::MIX_MUL_A;
        end else if (i_cmd.mul_b) begin
            r_z <= w_z_b * smxc_pkg::MIX_MUL_B;
        end
        if (i_cmd.finish) begin
            r_out <= r_data ^ w_key[smxc_pkg::BYTE_W-1:0];
        end else if (i_cmd.accept && !o_sts.need_mix) begin
            r_out <= i_data_byte ^ r_key[r_lane*smxc_pkg::BYTE_W +: smxc_pkg::BYTE_W];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out;

endmodule

>>> rtl/splitmix32_xor_byte_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix32_xor_byte_cipher
// Byte stream XOR cipher keyed by a SplitMix32-style generator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte with its
//   first-of-string flag and string index; output channel (o_out_valid /
//   i_out_stall) returns one transformed byte per input, in order.
//   Write the master seed through i_cfg_we / i_cfg_wdata while idle; it is
//   read when a string starts.
//   Bytes on lanes one to three of a key word go straight to the output
//   register and appear in the cycle after transfer. A byte that opens a
//   key word (first of a string, or every fourth byte) runs the
//   two-multiply mixer: multiply-A, then multiply-B, then a finish step
//   that loads the key word and the result; the input stalls meanwhile.
//   Reset clears the seed, generator state, key word and lane to zero and
//   empties the output register.
//   While the receiver stalls, the result holds in the output register;
//   one more key-word-opening byte may still be taken and mixed, then waits.
// ----------------------------------------------------------------------------
module splitmix32_xor_byte_cipher #(
    parameter int INDEX_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smxc_pkg::WORD_W-1:0]      i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [smxc_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                             i_first_byte,
    input  logic [smxc_pkg::STR_IDX_W-1:0]   i_string_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [smxc_pkg::BYTE_W-1:0]      o_result_byte
);

    smxc_pkg::t_dp_cmd w_cmd;
    smxc_pkg::t_dp_sts w_sts;

    smxc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    smxc_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_string_index (i_string_index),
        .i_out_stall    (i_out_stall),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_out_valid),
        .o_result_byte  (o_result_byte)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.mul_a, w_cmd.mul_b, w_cmd.finish}))
        else $error("more than one datapath command active");

    a_direct_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && !w_sts.need_mix) |=> o_out_valid)
        else $error("lane byte transfer did not produce a result");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("key word finish did not produce a result");

    a_mix_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_a |=> w_cmd.mul_b)
        else $error("mixer multiply steps out of order");

endmodule
